>>> rtl/lms_adaptive_fir_macros.svh
// assertion macros for the lms adaptive fir block
`ifndef LMS_ADAPTIVE_FIR_MACROS_SVH
`define LMS_ADAPTIVE_FIR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LMS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lms assertion failed");
`define LMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lms assertion failed");
`else
`define LMS_ASSERT_IMPL(label, ante, cons)
`define LMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/lms_pkg.sv
// shared widths, constants and types of the lms adaptive fir block
`default_nettype none

package lms_pkg;

	localparam int TAPS_DEF       = 8;
	localparam int WFB_DEF        = 29;

	localparam int SAMPLE_W       = 16;
	localparam int WEIGHT_W       = 32;
	localparam int PROD_W         = SAMPLE_W + WEIGHT_W;
	localparam int ERR_W          = 17;
	localparam int DPROD_W        = ERR_W + SAMPLE_W;
	localparam int SUM_W          = DPROD_W + 1;
	localparam int SHIFT_W        = 6;

	localparam logic [SHIFT_W-1:0] STEP_SHIFT_RST = 6'd40;

	typedef struct packed {
		logic shift;
		logic mul;
		logic acc;
		logic upd_mul;
		logic upd_add;
	} lms_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/lms_cell.sv
// one filter tap: sample, weight, product and weight update
`default_nettype none

module lms_cell import lms_pkg::*; (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire lms_ctrl_t                   ctrl,
	input  wire logic signed [SAMPLE_W-1:0]  x_in,
	input  wire logic signed [PROD_W-1:0]    prod_in,
	input  wire logic signed [ERR_W-1:0]     err,
	input  wire logic        [SHIFT_W-1:0]   step_shift,
	output logic signed [SAMPLE_W-1:0]       x_out,
	output logic signed [PROD_W-1:0]         prod_out
);

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [DPROD_W-1:0]  dprod_q;
	logic signed [PROD_W-1:0]   prod_c;
	logic signed [DPROD_W-1:0]  dprod_c;
	logic signed [DPROD_W-1:0]  delta_c;
	logic signed [SUM_W-1:0]    sum_c;
	logic signed [WEIGHT_W-1:0] w_next;
	logic                       fits_c;

	assign prod_c  = PROD_W'(w_q) * PROD_W'(x_q);
	assign dprod_c = DPROD_W'(err) * DPROD_W'(x_q);
	assign delta_c = dprod_q >>> step_shift;
	assign sum_c   = SUM_W'(delta_c) + SUM_W'(w_q);
	assign fits_c  = (&sum_c[SUM_W-1:WEIGHT_W-1]) | ~(|sum_c[SUM_W-1:WEIGHT_W-1]);

	always_comb begin
		if (fits_c) begin
			w_next = sum_c[WEIGHT_W-1:0];
		end else if (sum_c[SUM_W-1]) begin
			w_next = {1'b1, {(WEIGHT_W-1){1'b0}}};
		end else begin
			w_next = {1'b0, {(WEIGHT_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			w_q <= '0;
		end else begin
			if (ctrl.shift) begin
				x_q <= x_in;
			end
			if (ctrl.upd_add) begin
				w_q <= w_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= prod_c;
		end else if (ctrl.acc) begin
			prod_q <= prod_in;
		end
		if (ctrl.upd_mul) begin
			dprod_q <= dprod_c;
		end
	end

	assign x_out    = x_q;
	assign prod_out = prod_q;

endmodule

`default_nettype wire

>>> rtl/lms_adaptive_fir.sv
// lms adaptive fir top level: sequencer, accumulator, error and output register
// an accepted item runs S_MUL, S_ACC and S_ERR; the result is registered in S_ERR
// once the output is free; a new item is taken only in S_IDLE, after the weight
// update; the product chain drains through the accumulator one tap per cycle
// reset: delay line and weights clear, step_shift returns to 40, no item pending
`default_nettype none
`include "lms_adaptive_fir_macros.svh"

module lms_adaptive_fir import lms_pkg::*; #(
	parameter int TAPS             = TAPS_DEF,
	parameter int WEIGHT_FRAC_BITS = WFB_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [SHIFT_W-1:0]        cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic signed [SAMPLE_W-1:0] desired,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic signed [SAMPLE_W-1:0]     filter_out,
	output logic signed [ERR_W-1:0]        error_out
);

	localparam int ACC_W = PROD_W + $clog2(TAPS);
	localparam int CNT_W = $clog2(TAPS);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_MUL     = 6'b000010,
		S_ACC     = 6'b000100,
		S_ERR     = 6'b001000,
		S_UPD_MUL = 6'b010000,
		S_UPD_ADD = 6'b100000
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [SHIFT_W-1:0]         step_shift_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] desired_q;
	logic signed [ERR_W-1:0]    err_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] filter_out_q;
	logic signed [ERR_W-1:0]    error_out_q;

	lms_ctrl_t                  ctrl;
	logic                       in_acc;
	logic                       out_free;
	logic                       cnt_last;
	logic signed [ACC_W-1:0]    y_c;
	logic signed [ACC_W:0]      diff_c;
	logic signed [SAMPLE_W-1:0] fo_c;
	logic signed [ERR_W-1:0]    err_c;

	logic signed [SAMPLE_W-1:0] x_in_w   [TAPS];
	logic signed [SAMPLE_W-1:0] x_out_w  [TAPS];
	logic signed [PROD_W-1:0]   prod_in_w  [TAPS];
	logic signed [PROD_W-1:0]   prod_out_w [TAPS];

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign cnt_last  = (cnt_q == CNT_W'(TAPS - 1));

	assign ctrl.shift   = in_acc;
	assign ctrl.mul     = (state_q == S_MUL);
	assign ctrl.acc     = (state_q == S_ACC);
	assign ctrl.upd_mul = (state_q == S_UPD_MUL);
	assign ctrl.upd_add = (state_q == S_UPD_ADD);

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign x_in_w[k]    = sample_in;
			assign prod_in_w[k] = '0;
		end else begin : g_body
			assign x_in_w[k]    = x_out_w[k-1];
			assign prod_in_w[k] = prod_out_w[k-1];
		end

		lms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.x_in       (x_in_w[k]),
			.prod_in    (prod_in_w[k]),
			.err        (err_q),
			.step_shift (step_shift_q),
			.x_out      (x_out_w[k]),
			.prod_out   (prod_out_w[k])
		);
	end

	// output and error from the finished sum
	assign y_c    = acc_q >>> WEIGHT_FRAC_BITS;
	assign diff_c = (ACC_W+1)'(desired_q) - (ACC_W+1)'(y_c);

	always_comb begin
		if ((&y_c[ACC_W-1:SAMPLE_W-1]) | ~(|y_c[ACC_W-1:SAMPLE_W-1])) begin
			fo_c = y_c[SAMPLE_W-1:0];
		end else if (y_c[ACC_W-1]) begin
			fo_c = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			fo_c = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		if ((&diff_c[ACC_W:ERR_W-1]) | ~(|diff_c[ACC_W:ERR_W-1])) begin
			err_c = diff_c[ERR_W-1:0];
		end else if (diff_c[ACC_W]) begin
			err_c = {1'b1, {(ERR_W-1){1'b0}}};
		end else begin
			err_c = {1'b0, {(ERR_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			step_shift_q <= STEP_SHIFT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				step_shift_q <= cfg_data;
			end
			if ((state_q == S_ERR) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_UPD_MUL;
					end
				end
				S_UPD_MUL: begin
					state_q <= S_UPD_ADD;
				end
				S_UPD_ADD: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			desired_q <= desired;
		end
		if (state_q == S_MUL) begin
			acc_q <= '0;
		end else if (state_q == S_ACC) begin
			acc_q <= acc_q + ACC_W'(prod_out_w[TAPS-1]);
		end
		if ((state_q == S_ERR) && out_free) begin
			err_q        <= err_c;
			filter_out_q <= fo_c;
			error_out_q  <= err_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign filter_out = filter_out_q;
	assign error_out  = error_out_q;

	`LMS_ASSERT_NEXT(a_accept_starts_mul, in_valid && in_ready, state_q == S_MUL)
	`LMS_ASSERT_NEXT(a_acc_ends_after_taps, (state_q == S_ACC) && cnt_last, state_q == S_ERR)
	`LMS_ASSERT_IMPL(a_result_from_err, $rose(out_valid_q), $past(state_q == S_ERR))

endmodule

`default_nettype wire
